// File: rtl/page_allocator_with_refcounts_macros.svh
// assertion macros shared by the page allocator modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNTS_MACROS_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNTS_MACROS_SVH

// same-cycle implication
`define PGA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pga_pkg.sv
// shared types and constants of the page allocator
// no dependencies
package pga_pkg;

  // default sizing
  localparam int unsigned DefPageShift = 12;
  localparam int unsigned DefMaxPages  = 32768;
  localparam int unsigned DefCountBits = 16;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned RefCountW = 16;

  // register reset values
  localparam logic [AddrW-1:0] LowLimitReset  = 32'h8000_0000;
  localparam logic [AddrW-1:0] HighLimitReset = 32'h8800_0000;

  // register indexes
  localparam logic CfgLowLimit  = 1'b0;
  localparam logic CfgHighLimit = 1'b1;

  // action codes
  localparam logic [1:0] ActAlloc  = 2'd0;
  localparam logic [1:0] ActFree   = 2'd1;
  localparam logic [1:0] ActAddRef = 2'd2;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StOom     = 2'd1,
    StBadAddr = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [AddrW-1:0] phys_address;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [AddrW-1:0]     page_address;
    logic [RefCountW-1:0] ref_count;
    logic                 page_released;
  } out_item_t;

  // count store control
  typedef struct packed {
    logic rd;
    logic wr;
  } cnt_ctl_t;

  // free stack control and status
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

endpackage

// File: rtl/page_allocator_with_refcounts.sv
// Page frame allocator with per-page reference counts. After reset the count
// memory is swept to zero, one entry a cycle, so no request is taken until
// the sweep is done (configuration writes are taken as ever). One request is
// handled at a time: free and add reference read the count memory, then write
// the count back; allocate reads the stack memory, then the count, then writes
// back; a bad address, an empty stack or an unused action goes straight to
// the result. A result waits in the output register if the consumer stalls;
// the next request is still taken, but its own result holds until that
// register frees up.
// depends on pga_pkg, pga_addr_chk, pga_cnt_store, pga_free_stack, macro header
`include "page_allocator_with_refcounts_macros.svh"

module page_allocator_with_refcounts #(
  parameter int unsigned PAGE_SHIFT = pga_pkg::DefPageShift,
  parameter int unsigned MAX_PAGES  = pga_pkg::DefMaxPages,
  parameter int unsigned COUNT_BITS = pga_pkg::DefCountBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pga_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pga_pkg::out_item_t        out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [pga_pkg::AddrW-1:0] cfg_wdata_i
);
  import pga_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PAGES);
  localparam logic [AddrW:0] PageMask  = (AddrW+1)'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [AddrW:0] BaseReset = ({1'b0, LowLimitReset} + PageMask) & ~PageMask;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SPop,
    SUpdate,
    SDirect
  } state_e;

  // configuration registers, base kept pre-rounded
  logic [AddrW-1:0] low_q, high_q;
  logic [AddrW:0]   base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowLimitReset;
      high_q <= HighLimitReset;
      base_q <= BaseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLowLimit: begin
          low_q  <= cfg_wdata_i;
          base_q <= ({1'b0, cfg_wdata_i} + PageMask) & ~PageMask;
        end
        CfgHighLimit: begin
          high_q <= cfg_wdata_i;
        end
        default: begin
          high_q <= high_q;
        end
      endcase
    end
  end

  // address check on the incoming request
  logic            chk_ok;
  logic [IdxW-1:0] chk_idx;

  pga_addr_chk #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_PAGES  (MAX_PAGES)
  ) u_addr_chk (
    .pa_i   (in_data_i.phys_address),
    .low_i  (low_q),
    .high_i (high_q),
    .base_i (base_q),
    .ok_o   (chk_ok),
    .idx_o  (chk_idx)
  );

  // memories
  cnt_ctl_t              cnt_ctl;
  logic [IdxW-1:0]       cnt_rd_idx;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  cnt_ready;
  stk_ctl_t              stk_ctl;
  logic [IdxW-1:0]       stk_rdata;
  stk_sts_t              stk_sts;

  state_e                state_q, state_d;
  logic [1:0]            act_q, act_d;
  logic [AddrW-1:0]      pa_q, pa_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  status_e               st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  pga_cnt_store #(
    .MAX_PAGES  (MAX_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (cnt_ctl),
    .rd_idx_i  (cnt_rd_idx),
    .wr_idx_i  (idx_q),
    .wr_data_i (cnt_wdata),
    .rd_data_o (cnt_rdata),
    .ready_o   (cnt_ready)
  );

  pga_free_stack #(
    .MAX_PAGES (MAX_PAGES)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (stk_ctl),
    .push_idx_i (idx_q),
    .rd_data_o  (stk_rdata),
    .sts_o      (stk_sts)
  );

  // update arithmetic on the count just read
  logic                  in_fire;
  logic                  out_free;
  logic                  cnt_sat;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  cnt_gt1;
  logic [AddrW-1:0]      alloc_addr;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_sat    = (cnt_rdata == '1);
  assign cnt_inc    = cnt_sat ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
  assign cnt_dec    = cnt_rdata - COUNT_BITS'(1);
  assign cnt_gt1    = (cnt_rdata > COUNT_BITS'(1));
  assign alloc_addr = base_q[AddrW-1:0] + (AddrW'(idx_q) << PAGE_SHIFT);
  assign cnt_rd_idx = (state_q == SPop) ? stk_rdata : chk_idx;

  // request sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    pa_d        = pa_q;
    idx_d       = idx_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_ctl     = '0;
    stk_ctl     = '0;
    cnt_wdata   = '0;

    unique case (state_q)
      SClear: begin
        if (cnt_ready) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_fire) begin
          act_d = in_data_i.action;
          pa_d  = in_data_i.phys_address;
          idx_d = chk_idx;
          unique case (in_data_i.action) inside
            ActAlloc: begin
              if (stk_sts.empty) begin
                st_d    = StOom;
                state_d = SDirect;
              end else begin
                stk_ctl.rd = 1'b1;
                state_d    = SPop;
              end
            end
            ActFree, ActAddRef: begin
              if (chk_ok) begin
                cnt_ctl.rd = 1'b1;
                state_d    = SUpdate;
              end else begin
                st_d    = StBadAddr;
                state_d = SDirect;
              end
            end
            default: begin
              st_d    = StOk;
              state_d = SDirect;
            end
          endcase
        end
      end
      SPop: begin
        idx_d      = stk_rdata;
        cnt_ctl.rd = 1'b1;
        state_d    = SUpdate;
      end
      SUpdate: begin
        if (out_free) begin
          cnt_ctl.wr          = 1'b1;
          out_valid_d         = 1'b1;
          out_d.status        = StOk;
          out_d.page_address  = pa_q;
          out_d.page_released = 1'b0;
          if (act_q == ActFree) begin
            if (cnt_gt1) begin
              cnt_wdata       = cnt_dec;
              out_d.ref_count = RefCountW'(cnt_dec);
            end else begin
              cnt_wdata       = '0;
              out_d.ref_count = '0;
              if (stk_sts.full) begin
                out_d.status = StFull;
              end else begin
                stk_ctl.push        = 1'b1;
                out_d.page_released = 1'b1;
              end
            end
          end else begin
            // allocate and add reference both count one more reference
            cnt_wdata       = cnt_inc;
            out_d.ref_count = RefCountW'(cnt_inc);
            if (act_q == ActAlloc) begin
              stk_ctl.pop        = 1'b1;
              out_d.page_address = alloc_addr;
            end
          end
          state_d = SIdle;
        end
      end
      SDirect: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = st_q;
          out_d.page_address  = (st_q == StOom) ? '0 : pa_q;
          out_d.ref_count     = '0;
          out_d.page_released = 1'b0;
          state_d             = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      out_valid_q <= 1'b0;
      act_q       <= ActAlloc;
      pa_q        <= '0;
      idx_q       <= '0;
      st_q        <= StOk;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      act_q       <= act_d;
      pa_q        <= pa_d;
      idx_q       <= idx_d;
      st_q        <= st_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PGA_ASSERT_IMPL(a_no_accept_in_clear, !cnt_ready, !in_ready_o, "request taken during clear")
  `PGA_ASSERT_NEXT(a_one_in_flight, in_fire, !in_ready_o, "second request while one is busy")
  `PGA_ASSERT_IMPL(a_release_ok, out_valid_o && out_data_o.page_released, out_data_o.status == StOk, "release with error status")
  `PGA_ASSERT_IMPL(a_wb_needs_room, cnt_ctl.wr, out_free, "count write-back with output blocked")

endmodule

// File: rtl/pga_addr_chk.sv
// address check and page index computation for free and add reference
// depends on pga_pkg
module pga_addr_chk #(
  parameter int unsigned PAGE_SHIFT = pga_pkg::DefPageShift,
  parameter int unsigned MAX_PAGES  = pga_pkg::DefMaxPages,
  localparam int unsigned IdxW      = $clog2(MAX_PAGES)
) (
  input  logic [pga_pkg::AddrW-1:0] pa_i,
  input  logic [pga_pkg::AddrW-1:0] low_i,
  input  logic [pga_pkg::AddrW-1:0] high_i,
  input  logic [pga_pkg::AddrW:0]   base_i,
  output logic                      ok_o,
  output logic [IdxW-1:0]           idx_o
);
  import pga_pkg::*;

  logic [AddrW:0] pa_ext;
  logic [AddrW:0] offset;
  logic [AddrW:0] page_num;
  logic           aligned;
  logic           in_window;

  // offset from the rounded base, in pages
  assign pa_ext   = {1'b0, pa_i};
  assign offset   = pa_ext - base_i;
  assign page_num = offset >> PAGE_SHIFT;

  // alignment and window compares run side by side
  assign aligned   = (pa_i[PAGE_SHIFT-1:0] == '0);
  assign in_window = (pa_i >= low_i) && (pa_i < high_i) && (pa_ext >= base_i);

  assign ok_o  = aligned && in_window && (page_num < (AddrW+1)'(MAX_PAGES));
  assign idx_o = IdxW'(page_num);

endmodule

// File: rtl/pga_cnt_store.sv
// reference count memory with a clearing pass after reset
// depends on pga_pkg
module pga_cnt_store #(
  parameter int unsigned MAX_PAGES  = pga_pkg::DefMaxPages,
  parameter int unsigned COUNT_BITS = pga_pkg::DefCountBits,
  localparam int unsigned IdxW      = $clog2(MAX_PAGES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pga_pkg::cnt_ctl_t       ctl_i,
  input  logic [IdxW-1:0]         rd_idx_i,
  input  logic [IdxW-1:0]         wr_idx_i,
  input  logic [COUNT_BITS-1:0]   wr_data_i,
  output logic [COUNT_BITS-1:0]   rd_data_o,
  output logic                    ready_o
);
  import pga_pkg::*;

  logic [COUNT_BITS-1:0] mem [MAX_PAGES];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [IdxW-1:0]       clr_q, clr_d;
  logic                  busy_q, busy_d;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;

  // clearing sweep, one entry a cycle
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (clr_q == IdxW'(MAX_PAGES - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // write port shared by the sweep and the update path
  assign mem_we = busy_q || ctl_i.wr;
  assign mem_wa = busy_q ? clr_q : wr_idx_i;
  assign mem_wd = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rdata_q;
  assign ready_o   = !busy_q;

endmodule

// File: rtl/pga_free_stack.sv
// free page stack: index memory plus depth register
// depends on pga_pkg and the assertion macro header
`include "page_allocator_with_refcounts_macros.svh"

module pga_free_stack #(
  parameter int unsigned MAX_PAGES = pga_pkg::DefMaxPages,
  localparam int unsigned IdxW     = $clog2(MAX_PAGES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pga_pkg::stk_ctl_t ctl_i,
  input  logic [IdxW-1:0]   push_idx_i,
  output logic [IdxW-1:0]   rd_data_o,
  output pga_pkg::stk_sts_t sts_o
);
  import pga_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_PAGES + 1);

  logic [IdxW-1:0]   mem [MAX_PAGES];
  logic [IdxW-1:0]   rdata_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [IdxW-1:0]   top_addr;
  logic [IdxW-1:0]   wr_addr;

  // top entry sits one below the depth
  assign top_addr = IdxW'(depth_q - DepthW'(1));
  assign wr_addr  = IdxW'(depth_q);

  always_comb begin
    depth_d = depth_q;
    if (ctl_i.push) begin
      depth_d = depth_q + DepthW'(1);
    end else if (ctl_i.pop) begin
      depth_d = depth_q - DepthW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // index memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wr_addr] <= push_idx_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[top_addr];
    end
  end

  assign rd_data_o   = rdata_q;
  assign sts_o.empty = (depth_q == '0);
  assign sts_o.full  = (depth_q == DepthW'(MAX_PAGES));

  `PGA_ASSERT_IMPL(a_no_push_full, ctl_i.push, !sts_o.full, "push onto a full stack")
  `PGA_ASSERT_IMPL(a_no_pop_empty, ctl_i.pop || ctl_i.rd, !sts_o.empty, "pop from an empty stack")
  `PGA_ASSERT_IMPL(a_depth_bound, 1'b1, depth_q <= DepthW'(MAX_PAGES), "depth past capacity")
  `PGA_ASSERT_IMPL(a_push_pop_excl, ctl_i.push, !ctl_i.pop && !ctl_i.rd, "push with pop or read")

endmodule

// File: sim/page_allocator_with_refcounts_tb.sv
// testbench for the page allocator: directed, limit and random traffic tests
// mirrors free stack and reference counts to predict every result
// depends on pga_pkg and the page_allocator_with_refcounts rtl
module page_allocator_with_refcounts_tb;
  import pga_pkg::*;

  localparam int unsigned PageShift     = DefPageShift;
  localparam int unsigned MaxPages      = DefMaxPages;
  localparam int unsigned IdxW          = $clog2(DefMaxPages);
  localparam logic [32:0] PageMask      = (33'd1 << DefPageShift) - 33'd1;
  localparam logic [RefCountW-1:0] CountMax = '1;
  localparam logic [1:0]  ActUnused     = 2'd3;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned WatchdogLimit = 150000;
  localparam int unsigned PrintCap      = 40;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block inputs, known from time zero
  logic             in_valid_i  = 1'b0;
  in_item_t         in_data_i   = '0;
  logic             out_ready_i = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = CfgLowLimit;
  logic [AddrW-1:0] cfg_wdata_i = '0;
  logic             in_ready_o;
  logic             out_valid_o;
  out_item_t        out_data_o;

  page_allocator_with_refcounts #(
    .PAGE_SHIFT(DefPageShift),
    .MAX_PAGES (DefMaxPages),
    .COUNT_BITS(DefCountBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // mirrored allocator state
  logic [RefCountW-1:0] ref_count_mirror [MaxPages];
  logic [IdxW-1:0]      free_stack_mirror[MaxPages];
  int unsigned          stack_fill = 0;
  logic [AddrW-1:0]     low_limit_q  = LowLimitReset;
  logic [AddrW-1:0]     high_limit_q = HighLimitReset;
  out_item_t            expected_results[$];

  // limits as last written by the stimulus side
  logic [AddrW-1:0] cur_low  = LowLimitReset;
  logic [AddrW-1:0] cur_high = HighLimitReset;

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;

  initial begin
    for (int i = 0; i < MaxPages; i++) ref_count_mirror[i] = '0;
  end

  function automatic logic [32:0] managed_base(logic [AddrW-1:0] low);
    return ({1'b0, low} + PageMask) & ~PageMask;
  endfunction

  function automatic logic [RefCountW-1:0] sat_bump(logic [RefCountW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  // expected result of one request, updates the mirrored state
  function automatic out_item_t predict_page_op(in_item_t req);
    out_item_t       res;
    logic [32:0]     base;
    logic [32:0]     offs;
    logic [IdxW-1:0] idx;
    logic            addr_ok;
    res.status        = StOk;
    res.page_address  = req.phys_address;
    res.ref_count     = '0;
    res.page_released = 1'b0;
    base = managed_base(low_limit_q);
    offs = {1'b0, req.phys_address} - base;
    addr_ok = (req.phys_address[PageShift-1:0] == '0) &&
              (req.phys_address >= low_limit_q) && (req.phys_address < high_limit_q) &&
              ({1'b0, req.phys_address} >= base) && ((offs >> PageShift) < MaxPages);
    idx = offs[PageShift +: IdxW];
    case (req.action)
      ActAlloc: begin
        if (stack_fill == 0) begin
          res.status       = StOom;
          res.page_address = '0;
        end else begin
          stack_fill--;
          idx = free_stack_mirror[stack_fill];
          ref_count_mirror[idx] = sat_bump(ref_count_mirror[idx]);
          res.ref_count    = ref_count_mirror[idx];
          res.page_address = base[AddrW-1:0] + (AddrW'(idx) << PageShift);
        end
      end
      ActFree, ActAddRef: begin
        if (!addr_ok) begin
          res.status = StBadAddr;
        end else if (req.action == ActAddRef) begin
          ref_count_mirror[idx] = sat_bump(ref_count_mirror[idx]);
          res.ref_count = ref_count_mirror[idx];
        end else if (ref_count_mirror[idx] > 1) begin
          ref_count_mirror[idx] = ref_count_mirror[idx] - 1'b1;
          res.ref_count = ref_count_mirror[idx];
        end else begin
          ref_count_mirror[idx] = '0;
          if (stack_fill >= MaxPages) begin
            res.status = StFull;
          end else begin
            free_stack_mirror[stack_fill] = idx;
            stack_fill++;
            res.page_released = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // check results, mirror register writes, predict each input transfer
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.page_address, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", AddrW'(out_data_o.status), AddrW'(want.status));
          if (out_data_o.page_address !== want.page_address)
            report_mismatch("page_address", out_data_o.page_address, want.page_address);
          if (out_data_o.ref_count !== want.ref_count)
            report_mismatch("ref_count", AddrW'(out_data_o.ref_count), AddrW'(want.ref_count));
          if (out_data_o.page_released !== want.page_released)
            report_mismatch("page_released", AddrW'(out_data_o.page_released),
                            AddrW'(want.page_released));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLowLimit) low_limit_q = cfg_wdata_i;
        else high_limit_q = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) expected_results.push_back(predict_page_op(in_data_i));
    end
  end

  // receiver stall pattern: modes switch after random stretches
  logic [1:0]  rx_mode = 2'd0;
  int unsigned rx_left = 0;
  logic [3:0]  rx_tick = '0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1'b1;
    case (rx_mode)
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= (rx_tick[1:0] == 2'd0);
      default: out_ready_i <= rx_tick[3];
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("** page_allocator_with_refcounts: FAILED **");
    $finish;
  end

  // one request transfer, with random gaps between bursts
  task automatic send_item(input logic [1:0] act, input logic [AddrW-1:0] pa);
    in_item_t    req;
    int unsigned gap;
    req.action       = act;
    req.phys_address = pa;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [AddrW-1:0] low, input logic [AddrW-1:0] high);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgLowLimit;
    cfg_wdata_i <= low;
    @(posedge clk_i);
    cfg_idx_i   <= CfgHighLimit;
    cfg_wdata_i <= high;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cur_low  = low;
    cur_high = high;
  endtask

  function automatic logic [AddrW-1:0] page_at(int unsigned idx);
    logic [32:0] base;
    base = managed_base(cur_low);
    return base[AddrW-1:0] + (AddrW'(idx) << PageShift);
  endfunction

  // mostly pages of a small pool, plus misaligned, boundary and noise addresses
  function automatic logic [AddrW-1:0] pick_random_address();
    logic [32:0] base;
    logic [32:0] span;
    int unsigned last;
    int unsigned r;
    base = managed_base(cur_low);
    span = ({1'b0, cur_high} > base) ? ((({1'b0, cur_high} - base) + PageMask) >> PageShift) : '0;
    last = (span == 0) ? 0 : ((span > MaxPages) ? MaxPages - 1 : int'(span) - 1);
    r = $urandom_range(0, 99);
    if (r < 62) return page_at($urandom_range(0, 23));
    if (r < 68) return page_at(last);
    if (r < 76) return page_at($urandom_range(0, 23)) | AddrW'($urandom_range(1, 4095));
    if (r < 82) return cur_high - AddrW'($urandom_range(0, 1) << PageShift);
    if (r < 88) return cur_low - AddrW'(1 << PageShift);
    return $urandom;
  endfunction

  // edges of the address range, every action, empty stack and repeated free
  task automatic test_directed_edges();
    send_item(ActAlloc,  32'hFFFF_FFFF);
    send_item(ActFree,   32'h8000_0000);
    send_item(ActFree,   32'h87FF_F000);
    send_item(ActFree,   32'h8800_0000);
    send_item(ActFree,   32'h7FFF_F000);
    send_item(ActFree,   32'h8000_0800);
    send_item(ActAddRef, 32'hFFFF_FFFF);
    send_item(ActAddRef, 32'h0000_0000);
    send_item(ActAlloc,  32'h0000_0000);
    send_item(ActAddRef, 32'h87FF_F000);
    send_item(ActFree,   32'h87FF_F000);
    send_item(ActFree,   32'h87FF_F000);
    send_item(ActAlloc,  32'h0000_0000);
    send_item(ActAlloc,  32'h0000_0000);
    send_item(ActAlloc,  32'h0000_0000);
    send_item(ActUnused, 32'hFFFF_FFFF);
    send_item(ActUnused, 32'h0000_0000);
    send_item(ActFree,   32'h8000_0000);
    send_item(ActFree,   32'h8000_0000);
    send_item(ActFree,   32'h87FF_F000);
    drain_results();
  endtask

  // unaligned base, extreme limits, stacked pages rebuilt against a new base
  task automatic test_limit_settings();
    write_limits(32'h8000_0123, 32'h8001_0000);
    send_item(ActAlloc,  32'h0);
    send_item(ActFree,   32'h8000_0000);
    send_item(ActFree,   32'h8000_1000);
    send_item(ActAddRef, 32'h8000_F000);
    send_item(ActFree,   32'h8001_0000);
    send_item(ActAlloc,  32'h0);
    drain_results();
    write_limits(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ActFree,   32'h0000_0000);
    send_item(ActFree,   32'h07FF_F000);
    send_item(ActFree,   32'h0800_0000);
    send_item(ActAlloc,  32'h0);
    drain_results();
    write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ActFree,   32'hFFFF_F000);
    send_item(ActAddRef, 32'hFFFF_FFFF);
    send_item(ActAlloc,  32'h0);
    drain_results();
    write_limits(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_item(ActFree,   32'hFFFF_F000);
    send_item(ActAlloc,  32'h0);
    drain_results();
    write_limits(32'h0000_0000, 32'h0000_0000);
    send_item(ActFree,   32'h0000_0000);
    send_item(ActAddRef, 32'h0000_1000);
    send_item(ActAlloc,  32'h0);
    drain_results();
  endtask

  task automatic random_round(input int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 28) send_item(ActAlloc, $urandom);
      else if (r < 68) send_item(ActFree, pick_random_address());
      else if (r < 95) send_item(ActAddRef, pick_random_address());
      else send_item(ActUnused, $urandom);
    end
    drain_results();
  endtask

  // random traffic under three limit settings
  task automatic test_random_traffic();
    write_limits(LowLimitReset, HighLimitReset);
    random_round(170);
    write_limits(32'h8000_0123, 32'h8004_0000);
    random_round(170);
    write_limits(32'h0000_0000, 32'h0010_0000);
    random_round(170);
    write_limits(LowLimitReset, HighLimitReset);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_limit_settings();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("** page_allocator_with_refcounts: PASSED **");
    end else begin
      $display("** page_allocator_with_refcounts: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pga_pkg.sv
rtl/pga_addr_chk.sv
rtl/pga_cnt_store.sv
rtl/pga_free_stack.sv
rtl/page_allocator_with_refcounts.sv
sim/page_allocator_with_refcounts_tb.sv
